// ===== sv/scd_pkg.sv =====
// ----------------------------------------------------------------------------
// Serial command deframer package
// Framing characters, event codes and the result record that the deframer
// stages hand to each other.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package scd_pkg;

   localparam logic [7:0] NO_DATA_CHAR = 8'hFF;
   localparam logic [7:0] START_CHAR   = 8'h23;
   localparam logic [7:0] END_CHAR     = 8'h24;
   localparam logic [7:0] POLL_CHAR    = 8'h26;

   localparam int STOP_LEN = 4;
   localparam logic [7:0] STOP_TEXT [STOP_LEN] = '{8'h73, 8'h74, 8'h6F, 8'h70};

   typedef enum logic [2:0] {
      EV_BYTE    = 3'd0,
      EV_COMMIT  = 3'd1,
      EV_POLL    = 3'd2,
      EV_INVALID = 3'd3,
      EV_LONG    = 3'd4,
      EV_EMPTY   = 3'd5
   } event_kind_type;

   typedef struct packed {
      event_kind_type kind;
      logic [7:0]     payload_byte;
      logic [6:0]     frame_length;
      logic           is_stop;
   } event_type;

endpackage

// ===== sv/scd_step.sv =====
// ----------------------------------------------------------------------------
// Deframer step
// Holds the frame state and decodes one received byte into at most one event.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module scd_step #(
   parameter int MAX_PAYLOAD = 127
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              step_en,
   input  logic [7:0]        rx_byte,
   output logic              ev_valid,
   output scd_pkg::event_type ev
);
   import scd_pkg::*;

   localparam int CNT_W = $clog2(MAX_PAYLOAD + 1);
   localparam int EXT_W = 11;

   logic             in_frame_ff, in_frame_in;
   logic [CNT_W-1:0] byte_count_ff, byte_count_in;
   logic             stop_match_ff, stop_match_in;
   logic [EXT_W-1:0] count_ext;
   logic [CNT_W-1:0] count_inc;

   assign count_ext = EXT_W'(byte_count_ff);
   assign count_inc = byte_count_ff + CNT_W'(1);

   always_comb begin
      in_frame_in   = in_frame_ff;
      byte_count_in = byte_count_ff;
      stop_match_in = stop_match_ff;
      ev_valid      = 1'b0;
      ev            = '{kind: EV_BYTE, payload_byte: 8'h00, frame_length: 7'd0,
                        is_stop: 1'b0};
      if (rx_byte == NO_DATA_CHAR) begin
         ev_valid = 1'b0;
      end else if (rx_byte == POLL_CHAR) begin
         ev_valid = 1'b1;
         ev.kind  = EV_POLL;
      end else if (!in_frame_ff) begin
         if (rx_byte == START_CHAR) begin
            in_frame_in   = 1'b1;
            byte_count_in = '0;
            stop_match_in = 1'b1;
         end else begin
            ev_valid = 1'b1;
            ev.kind  = EV_INVALID;
         end
      end else if (rx_byte == END_CHAR) begin
         in_frame_in   = 1'b0;
         byte_count_in = '0;
         stop_match_in = 1'b1;
         ev_valid      = 1'b1;
         if (byte_count_ff == '0) begin
            ev.kind = EV_EMPTY;
         end else begin
            ev.kind         = EV_COMMIT;
            ev.frame_length = 7'(byte_count_ff);
            ev.is_stop      = stop_match_ff && (count_ext == EXT_W'(STOP_LEN));
         end
      end else if (byte_count_ff >= CNT_W'(MAX_PAYLOAD)) begin
         // Frame overflow: the byte is dropped and the frame is abandoned.
         in_frame_in     = 1'b0;
         byte_count_in   = '0;
         stop_match_in   = 1'b1;
         ev_valid        = 1'b1;
         ev.kind         = EV_LONG;
         ev.frame_length = 7'(byte_count_ff);
      end else begin
         if (count_ext < EXT_W'(STOP_LEN)) begin
            if (rx_byte != STOP_TEXT[count_ext[1:0]]) begin
               stop_match_in = 1'b0;
            end
         end else begin
            stop_match_in = 1'b0;
         end
         byte_count_in   = count_inc;
         ev_valid        = 1'b1;
         ev.kind         = EV_BYTE;
         ev.payload_byte = rx_byte;
         ev.frame_length = 7'(count_inc);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_frame_ff   <= 1'b0;
         byte_count_ff <= '0;
         stop_match_ff <= 1'b1;
      end else if (step_en) begin
         in_frame_ff   <= in_frame_in;
         byte_count_ff <= byte_count_in;
         stop_match_ff <= stop_match_in;
      end
   end

endmodule

// ===== sv/scd_rsp_reg.sv =====
// ----------------------------------------------------------------------------
// Deframer result register
// Holds one event until the downstream side takes the transaction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module scd_rsp_reg (
   input  logic               clock,
   input  logic               reset,
   input  logic               load,
   input  scd_pkg::event_type load_ev,
   output logic               free,
   input  logic               rsp_ready,
   output logic               rsp_valid,
   output scd_pkg::event_type rsp_ev
);
   import scd_pkg::*;

   logic      valid_ff, valid_in;
   event_type ev_ff;

   assign free      = !valid_ff || rsp_ready;
   assign valid_in  = load || (valid_ff && !rsp_ready);
   assign rsp_valid = valid_ff;
   assign rsp_ev    = ev_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         ev_ff <= load_ev;
      end
   end

endmodule

// ===== sv/serial_command_deframer.sv =====
// ----------------------------------------------------------------------------
// Serial command deframer
// Input register, then result register; no-data and frame-start bytes give no result.
// Throughput: one byte per cycle while the result channel keeps up.
// Reset: synchronous, active high; clears both registers and returns to waiting.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module serial_command_deframer #(
   parameter int MAX_PAYLOAD = 127
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_rx_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [2:0] rsp_event_kind,
   output logic [7:0] rsp_payload_byte,
   output logic [6:0] rsp_frame_length,
   output logic       rsp_is_stop
);
   import scd_pkg::*;

   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       advance;
   logic       ev_valid;
   event_type  ev;
   logic       out_free;
   event_type  rsp_ev;

   // The held byte is retired once its event (if any) fits in the result register.
   assign advance     = in_valid_ff && (!ev_valid || out_free);
   assign req_ready   = !in_valid_ff || advance;
   assign in_valid_in = (req_valid && req_ready) || (in_valid_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff <= req_rx_byte;
      end
   end

   scd_step #(
      .MAX_PAYLOAD(MAX_PAYLOAD)
   ) u_step (
      .clock   (clock),
      .reset   (reset),
      .step_en (advance),
      .rx_byte (in_byte_ff),
      .ev_valid(ev_valid),
      .ev      (ev)
   );

   scd_rsp_reg u_rsp (
      .clock    (clock),
      .reset    (reset),
      .load     (advance && ev_valid),
      .load_ev  (ev),
      .free     (out_free),
      .rsp_ready(rsp_ready),
      .rsp_valid(rsp_valid),
      .rsp_ev   (rsp_ev)
   );

   assign rsp_event_kind   = rsp_ev.kind;
   assign rsp_payload_byte = rsp_ev.payload_byte;
   assign rsp_frame_length = rsp_ev.frame_length;
   assign rsp_is_stop      = rsp_ev.is_stop;

`ifndef NO_ASSERTIONS
   a_load_shows: assert property (@(posedge clock) disable iff (reset)
      (advance && ev_valid) |=> rsp_valid)
      else $error("loaded event did not appear on the result channel");

   a_stop_commit: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_is_stop) |->
         (rsp_event_kind == EV_COMMIT && rsp_frame_length == 7'd4))
      else $error("stop flag on something other than a four-byte commit");

   a_payload_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_event_kind != EV_BYTE) |-> (rsp_payload_byte == 8'h00))
      else $error("payload byte set on a non-payload event");

   a_no_data_silent: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && in_byte_ff == NO_DATA_CHAR) |-> (!ev_valid && advance))
      else $error("no-data byte produced an event or stalled");
`endif

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// Serial command deframer testbench
// Feeds received bytes through the valid/ready byte channel and checks every
// event against an in-bench model of the frame parser or a directed table. The table covers
// the framing corner cases. Random traffic follows: mostly well-formed
// frames, with stray bytes, polls, no-data bytes and unterminated frames mixed
// in. Both channels idle at varying rates, and the event side is held off
// long enough to back up the input.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

   import scd_pkg::*;

   localparam int MAX_PAYLOAD       = 127;
   localparam int LONG_HOLD_CYCLES  = 300;
   localparam int WATCHDOG_LIMIT    = 2000;
   localparam int DRAIN_CYCLES      = 10;
   localparam int ITEMS_PER_PHASE   = 643;
   localparam int DIRECTED_ROWS     = 21;

   logic       clock = 1'b0;
   logic       reset;
   logic       req_valid;
   logic       req_ready;
   logic [7:0] req_rx_byte;
   logic       rsp_valid;
   logic       rsp_ready;
   logic [2:0] rsp_event_kind;
   logic [7:0] rsp_payload_byte;
   logic [6:0] rsp_frame_length;
   logic       rsp_is_stop;

   serial_command_deframer #(
      .MAX_PAYLOAD(MAX_PAYLOAD)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_rx_byte(req_rx_byte),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_event_kind(rsp_event_kind),
      .rsp_payload_byte(rsp_payload_byte),
      .rsp_frame_length(rsp_frame_length),
      .rsp_is_stop(rsp_is_stop)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Parser state kept by the bench.
   logic       frame_open = 1'b0;
   logic [6:0] payload_count = '0;
   logic       stop_prefix_ok = 1'b1;

   event_type   expected_events [$];
   int unsigned error_count = 0;
   int unsigned items_sent = 0;
   int unsigned frames_sent = 0;
   int          req_idle_pct = 0;
   int          rsp_idle_pct = 0;
   bit          rsp_hold_request = 1'b0;
   int unsigned quiet_cycles = 0;

   typedef struct packed {
      logic [7:0]     rx;
      logic           is_typed;
      event_kind_type kind;
      logic [6:0]     length;
      logic           want_stop;
   } directed_row_type;

   // Rows with is_typed set carry their expected event; the rest are predicted.
   directed_row_type directed_table [DIRECTED_ROWS] = '{
      '{8'h41, 1'b1, EV_INVALID, 7'd0, 1'b0},
      '{8'hFF, 1'b0, EV_BYTE,    7'd0, 1'b0},
      '{8'h26, 1'b1, EV_POLL,    7'd0, 1'b0},
      '{8'h24, 1'b1, EV_INVALID, 7'd0, 1'b0},
      '{8'h00, 1'b1, EV_INVALID, 7'd0, 1'b0},
      '{8'hFE, 1'b1, EV_INVALID, 7'd0, 1'b0},
      '{8'h23, 1'b0, EV_BYTE,    7'd0, 1'b0},
      '{8'h24, 1'b1, EV_EMPTY,   7'd0, 1'b0},
      '{8'h23, 1'b0, EV_BYTE,    7'd0, 1'b0},
      '{8'h73, 1'b1, EV_BYTE,    7'd1, 1'b0},
      '{8'h74, 1'b0, EV_BYTE,    7'd0, 1'b0},
      '{8'h6F, 1'b0, EV_BYTE,    7'd0, 1'b0},
      '{8'h70, 1'b0, EV_BYTE,    7'd0, 1'b0},
      '{8'h24, 1'b1, EV_COMMIT,  7'd4, 1'b1},
      '{8'h23, 1'b0, EV_BYTE,    7'd0, 1'b0},
      '{8'h00, 1'b0, EV_BYTE,    7'd0, 1'b0},
      '{8'h26, 1'b1, EV_POLL,    7'd0, 1'b0},
      '{8'hFF, 1'b0, EV_BYTE,    7'd0, 1'b0},
      '{8'h23, 1'b0, EV_BYTE,    7'd0, 1'b0},
      '{8'h80, 1'b0, EV_BYTE,    7'd0, 1'b0},
      '{8'h24, 1'b1, EV_COMMIT,  7'd3, 1'b0}
   };

   function automatic void close_frame();
      frame_open = 1'b0;
      payload_count = '0;
      stop_prefix_ok = 1'b1;
   endfunction

   // Advances the parser by one byte; returns 1 when the byte yields an event.
   function automatic bit deframe_byte(input logic [7:0] rx, output event_type evt);
      evt = '0;
      if (rx == NO_DATA_CHAR)
         return 1'b0;
      if (rx == POLL_CHAR) begin
         evt.kind = EV_POLL;
         return 1'b1;
      end
      if (!frame_open) begin
         if (rx == START_CHAR) begin
            frame_open = 1'b1;
            payload_count = '0;
            stop_prefix_ok = 1'b1;
            return 1'b0;
         end
         evt.kind = EV_INVALID;
         return 1'b1;
      end
      if (rx == END_CHAR) begin
         if (payload_count == 0) begin
            evt.kind = EV_EMPTY;
         end else begin
            evt.kind = EV_COMMIT;
            evt.frame_length = payload_count;
            evt.is_stop = stop_prefix_ok && (payload_count == STOP_LEN);
         end
         close_frame();
         return 1'b1;
      end
      // A payload byte past the limit aborts the frame and is dropped.
      if (payload_count >= MAX_PAYLOAD) begin
         evt.kind = EV_LONG;
         evt.frame_length = payload_count;
         close_frame();
         return 1'b1;
      end
      if (payload_count < STOP_LEN) begin
         if (rx != STOP_TEXT[payload_count])
            stop_prefix_ok = 1'b0;
      end else begin
         stop_prefix_ok = 1'b0;
      end
      payload_count = payload_count + 7'd1;
      evt.kind = EV_BYTE;
      evt.payload_byte = rx;
      evt.frame_length = payload_count;
      return 1'b1;
   endfunction

   function automatic logic [7:0] random_payload_char();
      logic [7:0] b;
      do
         b = 8'($urandom_range(255));
      while (b == END_CHAR || b == POLL_CHAR || b == NO_DATA_CHAR);
      return b;
   endfunction

   // Offers one byte and returns at the edge where the transaction completes.
   task automatic present_byte(input logic [7:0] rx);
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_rx_byte <= rx;
      do
         @(posedge clock);
      while (!req_ready);
   endtask

   task automatic send_byte(input logic [7:0] rx);
      event_type evt;
      present_byte(rx);
      if (deframe_byte(rx, evt))
         expected_events.push_back(evt);
      items_sent++;
   endtask

   task automatic send_frame();
      int unsigned len;
      int unsigned flip_pos;
      bit          stop_like;
      logic [7:0]  b;
      stop_like = 1'b0;
      flip_pos = 0;
      // The first two frames hit the length limit: one aborts, one commits at the maximum.
      if (frames_sent == 0)
         len = MAX_PAYLOAD + 1;
      else if (frames_sent == 1)
         len = MAX_PAYLOAD;
      else if ($urandom_range(99) == 0)
         len = $urandom_range(MAX_PAYLOAD + 3, MAX_PAYLOAD - 3);
      else if ($urandom_range(3) == 0) begin
         stop_like = 1'b1;
         len = $urandom_range(5, 3);
         flip_pos = $urandom_range(7);
      end else if ($urandom_range(4) == 0)
         len = $urandom_range(40, 9);
      else
         len = $urandom_range(8);
      frames_sent++;
      send_byte(START_CHAR);
      for (int unsigned i = 0; i < len; i++) begin
         if ($urandom_range(19) == 0)
            send_byte($urandom_range(1) ? POLL_CHAR : NO_DATA_CHAR);
         if (stop_like && i < STOP_LEN)
            b = STOP_TEXT[i] ^ ((i == flip_pos) ? 8'h01 : 8'h00);
         else
            b = random_payload_char();
         send_byte(b);
      end
      send_byte(END_CHAR);
   endtask

   task automatic wait_for_drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_events.size() != 0)
         @(posedge clock);
   endtask

   task automatic run_directed();
      event_type predicted;
      event_type typed_event;
      bit        produced;
      for (int r = 0; r < DIRECTED_ROWS; r++) begin
         present_byte(directed_table[r].rx);
         produced = deframe_byte(directed_table[r].rx, predicted);
         if (directed_table[r].is_typed) begin
            typed_event.kind = directed_table[r].kind;
            typed_event.payload_byte =
               (directed_table[r].kind == EV_BYTE) ? directed_table[r].rx : 8'h00;
            typed_event.frame_length = directed_table[r].length;
            typed_event.is_stop = directed_table[r].want_stop;
            expected_events.push_back(typed_event);
         end else if (produced) begin
            expected_events.push_back(predicted);
         end
      end
      wait_for_drain();
   endtask

   task automatic run_phase(input int send_pct, input int recv_pct, input int unsigned count);
      int unsigned goal;
      int unsigned pick;
      req_idle_pct = send_pct;
      rsp_idle_pct = recv_pct;
      goal = items_sent + count;
      while (items_sent < goal) begin
         pick = $urandom_range(99);
         if (pick < 65) begin
            send_frame();
         end else if (pick < 85) begin
            send_byte(8'($urandom_range(255)));
         end else begin
            // Unterminated frame: later bytes land inside it.
            send_byte(START_CHAR);
            repeat ($urandom_range(6))
               send_byte(8'($urandom_range(255)));
         end
      end
      wait_for_drain();
   endtask

   initial begin
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_rx_byte <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      run_directed();
      run_phase(21, 51, ITEMS_PER_PHASE);
      run_phase(51, 21, ITEMS_PER_PHASE);
      // Stall the event side while bytes keep coming so the input backs up.
      rsp_hold_request = 1'b1;
      run_phase(0, 0, ITEMS_PER_PHASE);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

   initial begin
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_hold_request) begin
            rsp_hold_request = 1'b0;
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD_CYCLES) @(posedge clock);
         end
         rsp_ready <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   task automatic compare_event(input event_type want);
      if (rsp_event_kind !== want.kind) begin
         $display("%0t: event_kind expected %0d actual %0d", $time, want.kind, rsp_event_kind);
         error_count++;
      end
      if (rsp_payload_byte !== want.payload_byte) begin
         $display("%0t: payload_byte expected %02h actual %02h",
                  $time, want.payload_byte, rsp_payload_byte);
         error_count++;
      end
      if (rsp_frame_length !== want.frame_length) begin
         $display("%0t: frame_length expected %0d actual %0d",
                  $time, want.frame_length, rsp_frame_length);
         error_count++;
      end
      if (rsp_is_stop !== want.is_stop) begin
         $display("%0t: is_stop expected %0b actual %0b", $time, want.is_stop, rsp_is_stop);
         error_count++;
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_events.size() == 0) begin
            $display("%0t: event with none expected, kind expected none actual %0d",
                     $time, rsp_event_kind);
            error_count++;
         end else begin
            compare_event(expected_events.pop_front());
         end
      end
   end

   // Ends the run when neither channel completes a transaction for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == WATCHDOG_LIMIT) begin
         $display("FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

endmodule

// ===== files.f =====
sv/scd_pkg.sv
sv/scd_step.sv
sv/scd_rsp_reg.sv
sv/serial_command_deframer.sv
tb/tb_top.sv
